// ===== rtl/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the crc byte update for the response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam int unsigned FrameLength = 9;

  localparam logic [3:0] PosAddress   = 4'd0;
  localparam logic [3:0] PosFunction  = 4'd1;
  localparam logic [3:0] PosByteCount = 4'd2;
  localparam logic [3:0] PosCrcLow    = 4'd7;
  localparam logic [3:0] PosCrcHigh   = 4'(FrameLength - 1);
  localparam logic [3:0] PosMax       = 4'hF;

  localparam logic [7:0] FuncReadHolding = 8'h03;
  localparam logic [7:0] DataByteCount   = 8'h04;
  localparam logic [7:0] AddressReset    = 8'h01;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadLen    = 3'd1;
  localparam logic [2:0] StBadAddr   = 3'd2;
  localparam logic [2:0] StBadFunc   = 3'd3;
  localparam logic [2:0] StBadCount  = 3'd4;
  localparam logic [2:0] StBadCrc    = 3'd5;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_item_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_read_response_checker_top.sv =====
// ----------------------------------------------------------------------------
// modbus_read_response_checker_top
// Checks Modbus RTU read-holding-registers responses byte by byte and reports
// one status per frame: 0 ok, 1 bad length, 2 bad address, 3 bad function,
// 4 bad byte count, 5 bad crc. Takes one byte per clock; the crc byte update
// and header compares sit between the input register and the frame state, so
// a byte is held in the input register and the status appears in the result
// register on the cycle after the last byte is processed (out_valid_o rises
// once the last byte has passed the input and result registers). Input and
// result registers keep bytes flowing while a finished status waits to be
// taken; only the next frame's last byte waits in the input register until
// that status is taken, and the input stalls while it waits. The expected
// slave address resets to 1 and is written through the cfg channel.
// ----------------------------------------------------------------------------
module modbus_read_response_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic       end_of_frame_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import mrrc_pkg::*;

  frame_item_t in_item;
  frame_item_t stage_item;
  logic        stage_valid;
  logic        advance;
  logic        result_valid;
  logic [2:0]  result_status;
  logic [7:0]  address_q;

  assign in_item.frame_byte   = frame_byte_i;
  assign in_item.end_of_frame = end_of_frame_i;

  assign advance = stage_valid && (!stage_item.end_of_frame || !out_valid_o || out_ready_i);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= AddressReset;
    end else if (cfg_valid_i) begin
      address_q <= cfg_data_i;
    end
  end

  mrrc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  mrrc_frame_check u_frame_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (advance),
    .item_i             (stage_item),
    .expected_address_i (address_q),
    .result_valid_o     (result_valid),
    .status_o           (result_status)
  );

  mrrc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (result_valid),
    .status_i (result_status),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .status_o (status_o)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= StBadCrc))
    else $error("status code out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (stage_valid && stage_item.end_of_frame && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> stage_valid)
    else $error("accepted item not held in input register");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid |=> out_valid_o)
    else $error("frame status lost");

endmodule

// ===== rtl/mrrc_in_reg.sv =====
// ----------------------------------------------------------------------------
// mrrc_in_reg
// Input register: holds one received item until the check stage takes it.
// ----------------------------------------------------------------------------
module mrrc_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  mrrc_pkg::frame_item_t item_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output mrrc_pkg::frame_item_t item_o
);
  import mrrc_pkg::*;

  logic        valid_q, valid_d;
  frame_item_t item_q;
  logic        load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/mrrc_frame_check.sv =====
// ----------------------------------------------------------------------------
// mrrc_frame_check
// Per-frame state: byte count, running crc, first header error, crc low byte.
// Produces the frame status on the last byte.
// ----------------------------------------------------------------------------
module mrrc_frame_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  mrrc_pkg::frame_item_t item_i,
  input  logic [7:0]           expected_address_i,
  output logic                 result_valid_o,
  output logic [2:0]           status_o
);
  import mrrc_pkg::*;

  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  err_q, err_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  b;

  assign b = item_i.frame_byte;

  always_comb begin
    pos_d    = (pos_q != PosMax) ? pos_q + 4'd1 : pos_q;
    crc_d    = (pos_q < PosCrcLow) ? crc_update(crc_q, b) : crc_q;
    err_d    = err_q;
    crc_lo_d = crc_lo_q;
    case (pos_q)
      PosAddress: begin
        if (b != expected_address_i && err_q == StOk) err_d = StBadAddr;
      end
      PosFunction: begin
        if (b != FuncReadHolding && err_q == StOk) err_d = StBadFunc;
      end
      PosByteCount: begin
        if (b != DataByteCount && err_q == StOk) err_d = StBadCount;
      end
      PosCrcLow: begin
        crc_lo_d = b;
      end
      default: begin
      end
    endcase

    if (pos_q != PosCrcHigh) begin
      status_o = StBadLen;
    end else if (err_q != StOk) begin
      status_o = err_q;
    end else if (crc_lo_q != crc_q[7:0] || b != crc_q[15:8]) begin
      status_o = StBadCrc;
    end else begin
      status_o = StOk;
    end

    if (item_i.end_of_frame) begin
      pos_d    = '0;
      crc_d    = CrcInit;
      err_d    = StOk;
      crc_lo_d = '0;
    end
  end

  assign result_valid_o = fire_i && item_i.end_of_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= CrcInit;
      err_q    <= StOk;
      crc_lo_q <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      err_q    <= err_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

// ===== rtl/mrrc_out_reg.sv =====
// ----------------------------------------------------------------------------
// mrrc_out_reg
// Result register: holds one status item until the consumer takes it.
// ----------------------------------------------------------------------------
module mrrc_out_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [2:0] status_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [2:0] status_o
);
  import mrrc_pkg::*;

  logic       valid_q;
  logic [2:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;

endmodule
